[rtl/fixed_point_alu_top_macros.svh]
// Assertion macros shared by the ALU blocks.
// Depends on nothing; included inside module bodies.
`ifndef FIXED_POINT_ALU_TOP_MACROS_SVH
`define FIXED_POINT_ALU_TOP_MACROS_SVH
// implication checked on every edge outside reset
`define FPA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: label");
// non-overlapping implication (|=>), checked outside reset
`define FPA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: label");
`endif

[rtl/fpa_pkg.sv]
// Types and opcodes for the fixed-point ALU.
// Used by every ALU module.
`default_nettype none
package fpa_pkg;
  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
    OP_MIN = 4'd12, OP_MAX = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } opcode_t;

  typedef enum logic [1:0] {
    CLS_SIMPLE = 2'd0, CLS_MUL = 2'd1, CLS_DIV = 2'd2
  } op_class_t;

  localparam int OutWidth = 32;
endpackage
`default_nettype wire

[rtl/fpa_front.sv]
// Front end: accepts requests, truncates operands to WORD_WIDTH, classifies and queues them.
// Depends on fpa_pkg and fixed_point_alu_top_macros.svh.
`default_nettype none
module fpa_front #(
  parameter int WORD_WIDTH = 32,
  parameter int DEPTH_LOG2 = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [3:0]            in_opcode,
  input  wire logic [31:0]           in_operand_a,
  input  wire logic [31:0]           in_operand_b,
  output logic                       q_valid,
  input  wire logic                  q_pop,
  output fpa_pkg::opcode_t           q_op,
  output fpa_pkg::op_class_t         q_cls,
  output logic signed [WORD_WIDTH-1:0] q_a,
  output logic signed [WORD_WIDTH-1:0] q_b
);
  import fpa_pkg::*;
  `include "fixed_point_alu_top_macros.svh"
  localparam int Depth = 1 << DEPTH_LOG2;

  opcode_t                    op_mem [Depth];
  op_class_t                  cls_mem [Depth];
  logic [WORD_WIDTH-1:0]      a_mem [Depth];
  logic [WORD_WIDTH-1:0]      b_mem [Depth];
  logic [DEPTH_LOG2:0]        wp_r, wp_nxt, rp_r, rp_nxt;
  logic                       push;
  op_class_t                  cls;
  opcode_t                    op_in;

  assign op_in = opcode_t'(in_opcode);
  always_comb begin
    case (op_in)
      OP_MUL:  cls = CLS_MUL;
      OP_DIV:  cls = CLS_DIV;
      default: cls = CLS_SIMPLE;
    endcase
  end

  assign in_stall = (wp_r - rp_r) == (DEPTH_LOG2+1)'(Depth);
  assign push     = in_valid && !in_stall;
  assign q_valid  = wp_r != rp_r;
  assign wp_nxt   = wp_r + (DEPTH_LOG2+1)'(push);
  assign rp_nxt   = rp_r + (DEPTH_LOG2+1)'(q_pop && q_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_mem[wp_r[DEPTH_LOG2-1:0]]  <= op_in;
      cls_mem[wp_r[DEPTH_LOG2-1:0]] <= cls;
      a_mem[wp_r[DEPTH_LOG2-1:0]]   <= in_operand_a[WORD_WIDTH-1:0];
      b_mem[wp_r[DEPTH_LOG2-1:0]]   <= in_operand_b[WORD_WIDTH-1:0];
    end
  end

  assign q_op  = op_mem[rp_r[DEPTH_LOG2-1:0]];
  assign q_cls = cls_mem[rp_r[DEPTH_LOG2-1:0]];
  assign q_a   = a_mem[rp_r[DEPTH_LOG2-1:0]];
  assign q_b   = b_mem[rp_r[DEPTH_LOG2-1:0]];

  `FPA_ASSERT_IMP(a_fill_bound, 1'b1, (wp_r - rp_r) <= (DEPTH_LOG2+1)'(Depth))
  `FPA_ASSERT_NXT(a_push_seen, push && !(q_pop && q_valid), q_valid)
  `FPA_ASSERT_IMP(a_full_stall, in_stall, q_valid)
endmodule
`default_nettype wire

[rtl/fpa_divider.sv]
// Radix-2 restoring divider for the divide opcode, one quotient bit a cycle.
// Depends on fpa_pkg.
`default_nettype none
module fpa_divider #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [WORD_WIDTH-1:0] a,
  input  wire logic signed [WORD_WIDTH-1:0] b,
  output logic                         busy,
  output logic                         done,
  output logic [WORD_WIDTH-1:0]        quot
);
  import fpa_pkg::*;
  localparam int CntW = $clog2(WORD_WIDTH + 1);

  logic [WORD_WIDTH-1:0] num, mag_n, mag_d;
  logic [WORD_WIDTH-1:0] q_r, q_nxt, d_r;
  logic [WORD_WIDTH:0]   rem_r, rem_nxt, trial;
  logic [CntW-1:0]       cnt_r, cnt_nxt;
  logic                  neg_r, busy_r, busy_nxt, done_r, done_nxt;

  assign num   = a << FRAC_BITS;
  assign mag_n = num[WORD_WIDTH-1] ? -num : num;
  assign mag_d = b[WORD_WIDTH-1] ? -b : b;
  assign trial = {rem_r[WORD_WIDTH-1:0], q_r[WORD_WIDTH-1]};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = mag_n;
      cnt_nxt  = CntW'(WORD_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[WORD_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[WORD_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      d_r   <= mag_d;
      neg_r <= num[WORD_WIDTH-1] ^ b[WORD_WIDTH-1];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = neg_r ? -q_r : q_r;
endmodule
`default_nettype wire

[rtl/fpa_back.sv]
// Back end: executes queued requests and holds results in an output register.
// Depends on fpa_pkg, fpa_divider and fixed_point_alu_top_macros.svh.
`default_nettype none
module fpa_back #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  output logic                       q_pop,
  input  wire fpa_pkg::opcode_t      q_op,
  input  wire fpa_pkg::op_class_t    q_cls,
  input  wire logic signed [WORD_WIDTH-1:0] q_a,
  input  wire logic signed [WORD_WIDTH-1:0] q_b,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [31:0]                out_result_word,
  output logic                       out_compare_true,
  output logic                       out_divide_by_zero
);
  import fpa_pkg::*;
  `include "fixed_point_alu_top_macros.svh"
  localparam int PW = 2 * WORD_WIDTH;

  // stage 1: simple ops and multiply product; stage 2: output register
  logic                  s1_v_r, s1_v_nxt, s1_mul_r;
  logic [WORD_WIDTH-1:0] s1_res_r, s1_res_nxt;
  logic                  s1_cmp_r, s1_cmp_nxt;
  logic signed [PW-1:0]  s1_prod_r;
  logic                  o_v_r, o_v_nxt, o_cmp_r, o_dz_r;
  logic [WORD_WIDTH-1:0] o_res_r;
  logic                  o_free, s1_adv, s1_free, div_busy, div_done, div_start;
  logic                  div_hold_r, div_pend;
  logic [WORD_WIDTH-1:0] div_q;
  logic signed [PW-1:0]  prod_sh;
  logic [WORD_WIDTH-1:0] s1_out;

  assign div_pend = div_done || div_hold_r;
  assign o_free  = !o_v_r || !out_stall;
  assign s1_adv  = s1_v_r && o_free && !div_pend;
  assign s1_free = !s1_v_r || s1_adv;
  assign div_start = q_valid && q_cls == CLS_DIV && q_b != '0 && !div_busy && !div_pend
                     && !s1_v_r;
  assign q_pop   = q_valid && s1_free && !div_busy && !div_pend &&
                   (q_cls != CLS_DIV || div_start || q_b == '0);

  always_comb begin
    s1_res_nxt = '0;
    s1_cmp_nxt = 1'b0;
    case (q_op)
      OP_ADD:      s1_res_nxt = q_a + q_b;
      OP_SUB:      s1_res_nxt = q_a - q_b;
      OP_GT:       s1_cmp_nxt = q_a > q_b;
      OP_LT:       s1_cmp_nxt = q_a < q_b;
      OP_GE:       s1_cmp_nxt = q_a >= q_b;
      OP_LE:       s1_cmp_nxt = q_a <= q_b;
      OP_EQ:       s1_cmp_nxt = q_a == q_b;
      OP_NE:       s1_cmp_nxt = q_a != q_b;
      OP_INC:      s1_res_nxt = q_a + 1'b1;
      OP_DEC:      s1_res_nxt = q_a - 1'b1;
      OP_MIN:      s1_res_nxt = (q_a < q_b) ? q_a : q_b;
      OP_MAX:      s1_res_nxt = (q_a > q_b) ? q_a : q_b;
      OP_FROM_INT: s1_res_nxt = q_a << FRAC_BITS;
      OP_TO_INT:   s1_res_nxt = q_a >>> FRAC_BITS;
      default:     s1_res_nxt = '0;
    endcase
  end

  // a zero-divisor divide flows through stage 1 with result 0
  assign s1_v_nxt = (q_pop && !div_start) ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  logic s1_dz_r;
  always_ff @(posedge clk) begin
    if (q_pop && !div_start) begin
      s1_res_r  <= s1_res_nxt;
      s1_cmp_r  <= s1_cmp_nxt;
      s1_mul_r  <= q_cls == CLS_MUL;
      s1_dz_r   <= q_cls == CLS_DIV;
      s1_prod_r <= PW'(q_a) * PW'(q_b);
    end
  end

  assign prod_sh = s1_prod_r >>> FRAC_BITS;
  assign s1_out  = s1_mul_r ? prod_sh[WORD_WIDTH-1:0] : s1_res_r;

  fpa_divider #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst_n, .start(div_start), .a(q_a), .b(q_b),
    .busy(div_busy), .done(div_done), .quot(div_q)
  );

  // divide result waits in div_q_r until the output register frees
  logic div_take;
  assign div_take = div_pend && o_free;
  assign o_v_nxt  = (s1_adv || div_take) ? 1'b1 : ((o_v_r && !out_stall) ? 1'b0 : o_v_r);

  logic [WORD_WIDTH-1:0] div_q_r;
  always_ff @(posedge clk) begin
    if (!rst_n) div_hold_r <= 1'b0;
    else div_hold_r <= div_pend && !o_free;
  end
  always_ff @(posedge clk) begin
    if (div_done) div_q_r <= div_q;
    if (div_take) begin
      o_res_r <= div_done ? div_q : div_q_r;
      o_cmp_r <= 1'b0;
      o_dz_r  <= 1'b0;
    end else if (s1_adv) begin
      o_res_r <= s1_dz_r ? '0 : s1_out;
      o_cmp_r <= s1_cmp_r;
      o_dz_r  <= s1_dz_r;
    end
  end

  assign out_valid          = o_v_r;
  assign out_result_word    = 32'(signed'(o_res_r));
  assign out_compare_true   = o_cmp_r;
  assign out_divide_by_zero = o_dz_r;

  `FPA_ASSERT_IMP(a_no_clash, div_take, !s1_adv)
  `FPA_ASSERT_IMP(a_div_alone, div_busy, !s1_v_r)
  `FPA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_result_word))
endmodule
`default_nettype wire

[rtl/fixed_point_alu_top.sv]
// Channel  | ports                                              | dir
// in       | in_valid in_stall in_opcode in_operand_a in_operand_b | in
// out      | out_valid out_stall out_result_word out_compare_true out_divide_by_zero | out
// All ops but divide: one request a cycle unless out_stall or a divide holds it up;
// path: queue, stage 1, output register. Divide: quotient from the one-bit-a-cycle divider
// loop; later requests wait in the queue until the quotient leaves.
// Synchronous active-low reset clears queue pointers, valid flags and divider state only.
// out_stall holds the output register; the 2-entry queue absorbs input.
// Depends on fpa_pkg, fpa_front, fpa_back, fpa_divider.
`default_nettype none
module fixed_point_alu_top #(
  parameter int FRAC_BITS  = 8,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_opcode,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_result_word,
  output logic             out_compare_true,
  output logic             out_divide_by_zero
);
  import fpa_pkg::*;

  logic                         q_valid, q_pop;
  opcode_t                      q_op;
  op_class_t                    q_cls;
  logic signed [WORD_WIDTH-1:0] q_a, q_b;

  fpa_front #(.WORD_WIDTH(WORD_WIDTH), .DEPTH_LOG2(1)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_operand_a, .in_operand_b,
    .q_valid, .q_pop, .q_op, .q_cls, .q_a, .q_b
  );

  fpa_back #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_op, .q_cls, .q_a, .q_b,
    .out_valid, .out_stall, .out_result_word, .out_compare_true, .out_divide_by_zero
  );
endmodule
`default_nettype wire
